/* sv/blfcc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blfcc_pkg
// Shared constants, status codes and the byte-wide CRC-32 update for the
// binary log frame CRC checker.
// ----------------------------------------------------------------------------
package blfcc_pkg;

	localparam int POS_W = 17;

	// Result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_CRC_BAD = 2'd1;
	localparam logic [1:0] ST_SHORT   = 2'd2;

	// Header byte positions
	localparam logic [POS_W-1:0] POS_HDR_LEN = 17'd3;
	localparam logic [POS_W-1:0] POS_ID_LO   = 17'd4;
	localparam logic [POS_W-1:0] POS_ID_HI   = 17'd5;
	localparam logic [POS_W-1:0] POS_LEN_LO  = 17'd8;
	localparam logic [POS_W-1:0] POS_LEN_HI  = 17'd9;

	localparam logic [POS_W-1:0] MIN_DATA_SIZE = 17'd10;
	localparam logic [POS_W-1:0] CRC_TRAILER_BYTES = 17'd4;
	localparam logic [1:0]       TRAILER_LAST = 2'd3;

	localparam logic [31:0] POLY_RESET = 32'hEDB8_8320;

	// Reflected CRC update over one byte, LSB first
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b,
			input logic [31:0] poly);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
		end
		return c;
	endfunction

endpackage

/* sv/blfcc_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blfcc channel interfaces
// Valid/ready channels for input bytes, frame results and the polynomial
// register write.
// ----------------------------------------------------------------------------
interface blfcc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_start;

	modport source (output valid, output data_byte, output frame_start, input ready);
	modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface blfcc_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  frame_status;
	logic [15:0] message_id;
	logic [16:0] frame_length;
	logic [31:0] computed_crc;

	modport source (output valid, output frame_status, output message_id,
		output frame_length, output computed_crc, input ready);
	modport sink   (input valid, input frame_status, input message_id,
		input frame_length, input computed_crc, output ready);
endinterface

interface blfcc_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] crc_polynomial;

	modport source (output valid, output crc_polynomial, input ready);
	modport sink   (input valid, input crc_polynomial, output ready);
endinterface

/* sv/binary_log_frame_crc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_log_frame_crc_checker
// Byte-wide frame parser with a reflected 32-bit CRC check (zero seed, no final XOR).
// ----------------------------------------------------------------------------
// Usage:
//   data_ch carries the frame stream, one word per byte; frame_start marks
//   the first byte of a frame and aborts any frame in progress. Bytes seen
//   outside a frame are dropped silently.
//   result_ch delivers one word per frame: status, message ID, total frame
//   length and the computed CRC. A frame whose declared header plus message
//   size is below 10 reports at its tenth byte with the short status.
//   cfg_ch writes the reflected polynomial; it is always ready and should be
//   written only while no frame is in flight.
// Timing:
//   One byte per cycle while no result waits. The full per-byte update (8-step
//   CRC, field capture, length compare) sits between the state registers and
//   the result register, so a result appears the cycle after its last byte is taken.
//   The result register frees in the same cycle it is read, so a stalled
//   receiver holds data_ch.ready low only while a result waits.
// Reset:
//   arst_n clears all frame state, drops any pending result and sets the
//   polynomial to 0xEDB88320.
// ----------------------------------------------------------------------------
module binary_log_frame_crc_checker (
	input  logic                   clk,
	input  logic                   arst_n,
	blfcc_byte_if.sink             data_ch,
	blfcc_result_if.source         result_ch,
	blfcc_cfg_if.sink              cfg_ch
);

	logic [31:0]                    poly_q;
	logic                           in_frame_q;
	logic [blfcc_pkg::POS_W-1:0]    pos_q;
	logic [31:0]                    crc_q;
	logic [7:0]                     hdr_len_q;
	logic [15:0]                    body_len_q;
	logic [15:0]                    ident_q;
	logic [31:0]                    rx_crc_q;

	logic                           out_valid_q;
	logic [1:0]                     out_status_q;
	logic [15:0]                    out_id_q;
	logic [16:0]                    out_len_q;
	logic [31:0]                    out_crc_q;

	// effective state after a possible start flag
	logic                           active;
	logic [blfcc_pkg::POS_W-1:0]    pos;
	logic [31:0]                    crc;
	logic [7:0]                     hdr_len;
	logic [15:0]                    body_len;
	logic [15:0]                    ident;
	logic [31:0]                    rx_crc;
	logic [blfcc_pkg::POS_W-1:0]    total;
	logic [blfcc_pkg::POS_W-1:0]    total_hdr;
	logic [1:0]                     trl_idx;
	logic [31:0]                    rx_crc_full;

	// next state and result
	logic                           in_frame_n;
	logic [blfcc_pkg::POS_W-1:0]    pos_n;
	logic [31:0]                    crc_n;
	logic [7:0]                     hdr_len_n;
	logic [15:0]                    body_len_n;
	logic [15:0]                    ident_n;
	logic [31:0]                    rx_crc_n;
	logic                           emit;
	logic [1:0]                     emit_status;
	logic [blfcc_pkg::POS_W-1:0]    emit_total;
	logic [31:0]                    emit_crc;

	logic                           acc;

	assign data_ch.ready = !out_valid_q || result_ch.ready;
	assign acc           = data_ch.valid && data_ch.ready;
	assign cfg_ch.ready  = 1'b1;

	always_comb begin
		active   = data_ch.frame_start || in_frame_q;
		pos      = data_ch.frame_start ? '0 : pos_q;
		crc      = data_ch.frame_start ? '0 : crc_q;
		hdr_len  = data_ch.frame_start ? '0 : hdr_len_q;
		body_len = data_ch.frame_start ? '0 : body_len_q;
		ident    = data_ch.frame_start ? '0 : ident_q;
		rx_crc   = data_ch.frame_start ? '0 : rx_crc_q;

		total       = {9'd0, hdr_len} + {1'b0, body_len};
		// size as known at the last header byte, with its high length byte
		total_hdr   = {9'd0, hdr_len} + {1'b0, data_ch.data_byte, body_len[7:0]};
		trl_idx     = 2'(pos - total);
		rx_crc_full = rx_crc | ({24'd0, data_ch.data_byte} << {trl_idx, 3'b000});

		in_frame_n  = active;
		pos_n       = 17'(pos + 17'd1);
		crc_n       = crc;
		hdr_len_n   = hdr_len;
		body_len_n  = body_len;
		ident_n     = ident;
		rx_crc_n    = rx_crc;
		emit        = 1'b0;
		emit_status = blfcc_pkg::ST_OK;
		emit_total  = total;
		emit_crc    = crc;

		if (pos < blfcc_pkg::MIN_DATA_SIZE) begin
			crc_n = blfcc_pkg::crc_byte(crc, data_ch.data_byte, poly_q);
			if (pos == blfcc_pkg::POS_HDR_LEN) hdr_len_n = data_ch.data_byte;
			if (pos == blfcc_pkg::POS_ID_LO)   ident_n[7:0] = data_ch.data_byte;
			if (pos == blfcc_pkg::POS_ID_HI)   ident_n[15:8] = data_ch.data_byte;
			if (pos == blfcc_pkg::POS_LEN_LO)  body_len_n[7:0] = data_ch.data_byte;
			if (pos == blfcc_pkg::POS_LEN_HI) begin
				body_len_n[15:8] = data_ch.data_byte;
				if (total_hdr < blfcc_pkg::MIN_DATA_SIZE) begin
					emit        = 1'b1;
					emit_status = blfcc_pkg::ST_SHORT;
					emit_total  = total_hdr;
					emit_crc    = '0;
				end
			end
		end else if (pos < total) begin
			crc_n = blfcc_pkg::crc_byte(crc, data_ch.data_byte, poly_q);
		end else begin
			rx_crc_n = rx_crc_full;
			if (trl_idx == blfcc_pkg::TRAILER_LAST) begin
				emit        = 1'b1;
				emit_status = (crc == rx_crc_full) ? blfcc_pkg::ST_OK
					: blfcc_pkg::ST_CRC_BAD;
			end
		end

		if (emit) begin
			in_frame_n = 1'b0;
			pos_n      = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= blfcc_pkg::POLY_RESET;
		end else if (cfg_ch.valid) begin
			poly_q <= cfg_ch.crc_polynomial;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			pos_q      <= '0;
			crc_q      <= '0;
			hdr_len_q  <= '0;
			body_len_q <= '0;
			ident_q    <= '0;
			rx_crc_q   <= '0;
		end else if (acc && active) begin
			in_frame_q <= in_frame_n;
			pos_q      <= pos_n;
			crc_q      <= crc_n;
			hdr_len_q  <= hdr_len_n;
			body_len_q <= body_len_n;
			ident_q    <= ident_n;
			rx_crc_q   <= rx_crc_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc && active && emit) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && active && emit) begin
			out_status_q <= emit_status;
			out_id_q     <= ident_n;
			out_len_q    <= 17'(emit_total + blfcc_pkg::CRC_TRAILER_BYTES);
			out_crc_q    <= emit_crc;
		end
	end

	assign result_ch.valid        = out_valid_q;
	assign result_ch.frame_status = out_status_q;
	assign result_ch.message_id   = out_id_q;
	assign result_ch.frame_length = out_len_q;
	assign result_ch.computed_crc = out_crc_q;

	// position is parked at zero between frames
	a_idle_pos: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> pos_q == '0)
		else $error("byte position nonzero outside a frame");

	// a reporting byte always closes the frame
	a_emit_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && active && emit) |=> (!in_frame_q && out_valid_q))
		else $error("frame still open after its result");

	// a checked frame spans at least ten data bytes plus the trailer
	a_checked_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q != blfcc_pkg::ST_SHORT) |-> out_len_q >= 17'd14)
		else $error("checked frame shorter than minimum");

	// a short frame reports no CRC and a length under the minimum
	a_short_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q == blfcc_pkg::ST_SHORT)
			|-> (out_crc_q == '0 && out_len_q < 17'd14))
		else $error("short frame result fields inconsistent");

endmodule
